@@ rtl/slug_pkg.sv @@
// Shared constants, command codes and status types of the shuffled Lehmer generator.
`default_nettype none

package slug_pkg;

	localparam int VALUE_W = 31;
	localparam int FRAC_W  = 24;
	localparam int PROD_W  = 46;
	localparam int MULT_W  = 15;

	// Table depth is a power of two so that the bucket size is one as well.
	localparam int TABLE_DEPTH  = 32;
	localparam int IDX_W        = $clog2(TABLE_DEPTH);
	localparam int WARM_TOTAL   = TABLE_DEPTH + 8;
	localparam int CNT_W        = $clog2(WARM_TOTAL);
	localparam longint BUCKET_SIZE  = 1 + (64'd2147483646 / TABLE_DEPTH);
	localparam int BUCKET_SHIFT = $clog2(BUCKET_SIZE);

	localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
	localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] SEED_MAX = 31'h7FFF_FFFE;
	localparam logic [FRAC_W-1:0]  FRAC_MAX = 24'd16777214;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] result;
	} mul_sts_t;

endpackage

`default_nettype wire

@@ rtl/slug_in_if.sv @@
// Request channel: command word with its reseed value.
`default_nettype none

interface slug_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [30:0] seed_value;

	modport source (output valid, command, seed_value, input ready);
	modport sink (input valid, command, seed_value, output ready);
endinterface

`default_nettype wire

@@ rtl/slug_out_if.sv @@
// Result channel: shuffled value, its Q0.24 fraction and the updated seed.
`default_nettype none

interface slug_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] raw_value;
	logic [23:0] uniform_fraction;
	logic [30:0] next_seed;

	modport source (output valid, raw_value, uniform_fraction, next_seed, input ready);
	modport sink (input valid, raw_value, uniform_fraction, next_seed, output ready);
endinterface

`default_nettype wire

@@ rtl/shuffled_lehmer_uniform_generator.sv @@
// Top level of the shuffled Lehmer uniform generator with its sequencer and shuffle table.
//
// Each request word yields exactly one result word. A draw runs one modular
// multiply through the two-stage multiplier, the table read overlapping it,
// then forms the fraction and loads the output register. The request side
// opens again only once the output register is loaded, so a new word is not
// taken before the last one has left the sequencer. A reseed, and the first
// draw after reset, first run 40 warm-up steps through the same multiplier
// before the draw. The shared multiplier starts no step before the last one
// has completed. The request side is ready only while the sequencer is idle;
// a finished result waits in the output register and the next request is
// taken meanwhile. The 32-entry table is a memory with a registered read; it
// is filled by every warm-up before it is read, so it needs no clearing
// after reset.
`default_nettype none

module shuffled_lehmer_uniform_generator (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slug_in_if.sink    request,
	slug_out_if.source result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WARM = 2'd1;
	localparam logic [1:0] ST_DRAW = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int VW = slug_pkg::VALUE_W;
	localparam int IW = slug_pkg::IDX_W;
	localparam int CW = slug_pkg::CNT_W;

	logic [1:0]    state_q;
	logic [VW-1:0] gen_seed_q;
	logic [VW-1:0] last_q;
	logic [CW-1:0] cnt_q;
	logic          mul_busy_q;

	logic [VW-1:0] table_mem [slug_pkg::TABLE_DEPTH];
	logic [VW-1:0] rd_data_q;

	logic          out_valid_q;
	logic [VW-1:0] out_raw_q;
	logic [slug_pkg::FRAC_W-1:0] out_frac_q;
	logic [VW-1:0] out_seed_q;

	logic               accept;
	logic               mul_start;
	slug_pkg::mul_sts_t mul_sts;
	logic [VW-1:0]      start_seed;
	logic [VW-1:0]      bucket;
	logic [IW-1:0]      draw_idx;
	logic [CW-1:0]      warm_pos;
	logic               out_free;
	logic [slug_pkg::FRAC_W-1:0] frac;

	assign accept    = request.valid && request.ready;
	assign out_free  = !out_valid_q || result.ready;
	assign mul_start = (state_q == ST_WARM || state_q == ST_DRAW) && !mul_busy_q;

	// Seed to warm up from: the request seed with zero and the modulus fixed,
	// or seed one when a plain draw finds the table never filled.
	always_comb begin
		if (request.command == slug_pkg::CMD_RESEED) begin
			if (request.seed_value == '0) begin
				start_seed = VW'(1);
			end else if (request.seed_value > slug_pkg::SEED_MAX) begin
				start_seed = slug_pkg::SEED_MAX;
			end else begin
				start_seed = request.seed_value;
			end
		end else begin
			start_seed = VW'(1);
		end
	end

	// Bucket of the last output picks the table entry; clamp to the last entry.
	always_comb begin
		bucket = last_q >> slug_pkg::BUCKET_SHIFT;
		if (bucket >= VW'(slug_pkg::TABLE_DEPTH)) begin
			draw_idx = IW'(slug_pkg::TABLE_DEPTH - 1);
		end else begin
			draw_idx = bucket[IW-1:0];
		end
	end

	// Warm-up steps fill the table from the top entry down to entry zero.
	assign warm_pos = CW'(slug_pkg::WARM_TOTAL - 1) - cnt_q;

	slug_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (gen_seed_q),
		.sts     (mul_sts)
	);

	slug_frac u_frac (
		.raw  (last_q),
		.frac (frac)
	);

	// Sequencer: idle, warm-up steps, one draw, load the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gen_seed_q <= VW'(1);
			last_q     <= '0;
			cnt_q      <= '0;
			mul_busy_q <= 1'b0;
		end else begin
			if (mul_start) begin
				mul_busy_q <= 1'b1;
			end else if (mul_sts.done) begin
				mul_busy_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (request.command == slug_pkg::CMD_RESEED || last_q == '0) begin
							gen_seed_q <= start_seed;
							state_q    <= ST_WARM;
						end else begin
							state_q <= ST_DRAW;
						end
					end
				end
				ST_WARM: begin
					if (mul_sts.done) begin
						gen_seed_q <= mul_sts.result;
						if (cnt_q == CW'(slug_pkg::WARM_TOTAL - 1)) begin
							// Prime the last output from entry zero, written just now.
							last_q  <= mul_sts.result;
							state_q <= ST_DRAW;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				ST_DRAW: begin
					if (mul_sts.done) begin
						gen_seed_q <= mul_sts.result;
						last_q     <= rd_data_q;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table: registered read at the draw index, write on warm-up and draw.
	always_ff @(posedge clk) begin
		rd_data_q <= table_mem[draw_idx];
		if (state_q == ST_WARM && mul_sts.done && warm_pos < CW'(slug_pkg::TABLE_DEPTH)) begin
			table_mem[warm_pos[IW-1:0]] <= mul_sts.result;
		end else if (state_q == ST_DRAW && mul_sts.done) begin
			table_mem[draw_idx] <= mul_sts.result;
		end
	end

	// Output register: load when free, drop valid once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_raw_q  <= last_q;
			out_frac_q <= frac;
			out_seed_q <= gen_seed_q;
		end
	end

	assign request.ready           = (state_q == ST_IDLE);
	assign result.valid            = out_valid_q;
	assign result.raw_value        = out_raw_q;
	assign result.uniform_fraction = out_frac_q;
	assign result.next_seed        = out_seed_q;

	// The generator seed never leaves the range 1 .. 2^31-2.
	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		gen_seed_q != '0 && gen_seed_q != slug_pkg::LCG_MOD)
		else $error("generator seed left its range");

	// The output is loaded only after a draw has completed.
	a_emit_after_draw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> $past(state_q == ST_DRAW || state_q == ST_EMIT))
		else $error("output stage entered without a draw");

	// A result word presented downstream always carries a drawn, nonzero value.
	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_raw_q != '0)
		else $error("result word carries a zero value");

	// The multiplier reports completion only for a step that was started.
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> mul_busy_q)
		else $error("multiplier completion without a start");

endmodule

`default_nettype wire

@@ rtl/slug_mulmod.sv @@
// Two-stage modular multiplier: operand * 16807 mod (2^31 - 1).
`default_nettype none

module slug_mulmod (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [slug_pkg::VALUE_W-1:0] operand,
	output slug_pkg::mul_sts_t                sts
);

	logic [slug_pkg::PROD_W-1:0]  prod_s1;
	logic                         v_s1;
	logic [slug_pkg::VALUE_W:0]   fold_sum;
	logic [slug_pkg::VALUE_W-1:0] fold_res;
	logic [slug_pkg::VALUE_W-1:0] result_q;
	logic                         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= slug_pkg::PROD_W'(operand) * slug_pkg::PROD_W'(slug_pkg::LCG_MULT);
		end
		if (v_s1) begin
			result_q <= fold_res;
		end
	end

	// Fold the high part back in, since 2^31 is one modulo the Mersenne prime.
	always_comb begin
		fold_sum = {1'b0, prod_s1[slug_pkg::VALUE_W-1:0]}
			+ (slug_pkg::VALUE_W + 1)'(prod_s1[slug_pkg::PROD_W-1:slug_pkg::VALUE_W]);
		if (fold_sum >= {1'b0, slug_pkg::LCG_MOD}) begin
			fold_res = slug_pkg::VALUE_W'(fold_sum - {1'b0, slug_pkg::LCG_MOD});
		end else begin
			fold_res = fold_sum[slug_pkg::VALUE_W-1:0];
		end
	end

	assign sts.done   = done_q;
	assign sts.result = result_q;

endmodule

`default_nettype wire

@@ rtl/slug_frac.sv @@
// Rounded raw / (2^31 - 1) in Q0.24, clamped below one.
`default_nettype none

module slug_frac (
	input  wire logic [slug_pkg::VALUE_W-1:0] raw,
	output logic      [slug_pkg::FRAC_W-1:0]  frac
);

	localparam int X_W = slug_pkg::VALUE_W + slug_pkg::FRAC_W;

	logic [X_W-1:0]                 x;
	logic [slug_pkg::FRAC_W-1:0]    q0;
	logic [slug_pkg::VALUE_W:0]     rem;
	logic [slug_pkg::FRAC_W:0]      q;

	// Dividing by 2^31 - 1: take x >> 31, then correct once on the remainder.
	always_comb begin
		x   = {raw, slug_pkg::FRAC_W'(0)} + X_W'(64'h4000_0000);
		q0  = x[X_W-1:slug_pkg::VALUE_W];
		rem = {1'b0, x[slug_pkg::VALUE_W-1:0]} + (slug_pkg::VALUE_W + 1)'(q0);
		q   = {1'b0, q0} + (slug_pkg::FRAC_W + 1)'(rem >= {1'b0, slug_pkg::LCG_MOD});
		if (q > {1'b0, slug_pkg::FRAC_MAX}) begin
			frac = slug_pkg::FRAC_MAX;
		end else begin
			frac = q[slug_pkg::FRAC_W-1:0];
		end
	end

endmodule

`default_nettype wire
